@@ rtl/core/rsd_pkg.sv @@
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared widths, constants and the per-item context of the stick conditioner.
// ----------------------------------------------------------------------------
package rsd_pkg;

  // full-scale stick deflection
  localparam int unsigned FULL_SCALE = 32767;

  // register reset values
  localparam logic [14:0] AXIS_DZ_RST   = 15'd7849;
  localparam logic [14:0] RADIAL_DZ_RST = 15'd7849;

  // register indexes (word address bit 2)
  localparam logic REG_AXIS_DZ   = 1'b0;
  localparam logic REG_RADIAL_DZ = 1'b1;

  // datapath widths
  localparam int unsigned SQ_W        = 48;  // radicand, squared length in q.16
  localparam int unsigned ROOT_W      = 24;  // length in q.8
  localparam int unsigned REM_W       = 24;  // divider remainder and divisor
  localparam int unsigned QUO_W       = 15;  // divider quotient
  localparam int unsigned SQRT_STAGES = ROOT_W;
  localparam int unsigned DIV_STAGES  = QUO_W;

  // accept to result strobe, in cycles
  localparam int unsigned LATENCY = 8 + SQRT_STAGES + 2 * DIV_STAGES;

  localparam logic [ROOT_W-1:0] FULL_Q8  = ROOT_W'(FULL_SCALE << 8);
  localparam logic [QUO_W-1:0]  TILT_MAX = QUO_W'(FULL_SCALE);

  // context that travels with each item
  typedef struct packed {
    logic              sign_x;
    logic              sign_y;
    logic [15:0]       ax;
    logic [15:0]       ay;
    logic [ROOT_W-1:0] magq;
    logic              live;
    logic              pushed;
    logic              sat;
    logic [QUO_W-1:0]  tilt;
  } ctx_t;

endpackage

@@ rtl/core/rsd_sqrt.sv @@
// ----------------------------------------------------------------------------
// rsd_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rsd_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [rsd_pkg::SQ_W-1:0]    rad_i,
  input  rsd_pkg::ctx_t               ctx_i,
  output logic                        valid_o,
  output logic [rsd_pkg::ROOT_W-1:0]  root_o,
  output rsd_pkg::ctx_t               ctx_o
);

  localparam int unsigned N = rsd_pkg::SQRT_STAGES;
  localparam int unsigned W = rsd_pkg::SQ_W;

  logic          v_q   [N];
  logic [W-1:0]  n_q   [N];
  logic [W-1:0]  res_q [N];
  rsd_pkg::ctx_t ctx_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
    logic          v_in;
    logic [W-1:0]  n_in, res_in, trial, n_nx, res_nx;
    rsd_pkg::ctx_t ctx_in;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign n_in   = rad_i;
      assign res_in = '0;
      assign ctx_in = ctx_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign n_in   = n_q[k-1];
      assign res_in = res_q[k-1];
      assign ctx_in = ctx_q[k-1];
    end

    // trial subtract of the next root bit
    always_comb begin
      trial = res_in + BIT;
      if (n_in >= trial) begin
        n_nx   = n_in - trial;
        res_nx = (res_in >> 1) + BIT;
      end else begin
        n_nx   = n_in;
        res_nx = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      n_q[k]   <= n_nx;
      res_q[k] <= res_nx;
      ctx_q[k] <= ctx_in;
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = res_q[N-1][rsd_pkg::ROOT_W-1:0];
  assign ctx_o   = ctx_q[N-1];

endmodule

@@ rtl/core/rsd_div.sv @@
// ----------------------------------------------------------------------------
// rsd_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rsd_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [rsd_pkg::REM_W-1:0]  rem_i,
  input  logic [rsd_pkg::QUO_W-1:0]  low_i,
  input  logic [rsd_pkg::REM_W-1:0]  div_i,
  input  rsd_pkg::ctx_t              ctx_i,
  output logic                       valid_o,
  output logic [rsd_pkg::QUO_W-1:0]  quo_o,
  output rsd_pkg::ctx_t              ctx_o
);

  localparam int unsigned N  = rsd_pkg::DIV_STAGES;
  localparam int unsigned RW = rsd_pkg::REM_W;
  localparam int unsigned QW = rsd_pkg::QUO_W;

  logic          v_q   [N];
  logic [RW-1:0] rem_q [N];
  logic [QW-1:0] low_q [N];
  logic [RW-1:0] div_q [N];
  logic [QW-1:0] quo_q [N];
  rsd_pkg::ctx_t ctx_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic          v_in, ge;
    logic [RW-1:0] rem_in, div_in, rem_nx;
    logic [QW-1:0] low_in, quo_in;
    logic [RW:0]   t, diff;
    rsd_pkg::ctx_t ctx_in;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = rem_i;
      assign low_in = low_i;
      assign div_in = div_i;
      assign quo_in = '0;
      assign ctx_in = ctx_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign div_in = div_q[k-1];
      assign quo_in = quo_q[k-1];
      assign ctx_in = ctx_q[k-1];
    end

    // shift in the next dividend bit and try the subtract
    always_comb begin
      t      = {rem_in, low_in[QW-1]};
      diff   = t - {1'b0, div_in};
      ge     = (t >= {1'b0, div_in});
      rem_nx = ge ? diff[RW-1:0] : t[RW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_nx;
      low_q[k] <= {low_in[QW-2:0], 1'b0};
      div_q[k] <= div_in;
      quo_q[k] <= {quo_in[QW-2:0], ge};
      ctx_q[k] <= ctx_in;
    end
  end

  assign valid_o = v_q[N-1];
  assign quo_o   = quo_q[N-1];
  assign ctx_o   = ctx_q[N-1];

endmodule

@@ rtl/core/radial_stick_deadzone_unit.sv @@
// ----------------------------------------------------------------------------
// radial_stick_deadzone_unit
// Per-axis gate, radial dead zone and rescaling of one analog stick sample.
// ----------------------------------------------------------------------------
// throughput: one item per cycle, busy stays low; fixed by the pipelined
//   square root (24 stages) and the tilt and axis dividers (15 stages each)
// reset: pipeline empties, dead zone registers return to 7849
// the result strobe lasts one cycle and the receiver cannot stall
module radial_stick_deadzone_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] stick_x_i,
  input  logic [15:0] stick_y_i,
  output logic        done_o,
  output logic [15:0] scaled_x_o,
  output logic [15:0] scaled_y_o,
  output logic [14:0] tilt_length_o,
  output logic        pushed_o
);

  localparam int unsigned RTW = rsd_pkg::ROOT_W;
  localparam int unsigned QW  = rsd_pkg::QUO_W;

  // configuration registers
  logic [14:0]     adz_q, rdz_q;
  logic [29:0]     rdz_sq_q;
  logic [RTW-1:0]  den_q;
  logic            rdz_ok_q;
  logic            wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adz_q <= rsd_pkg::AXIS_DZ_RST;
      rdz_q <= rsd_pkg::RADIAL_DZ_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        rsd_pkg::REG_AXIS_DZ:   adz_q <= pwdata[14:0];
        rsd_pkg::REG_RADIAL_DZ: rdz_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rsd_pkg::REG_AXIS_DZ:   prdata = {17'd0, adz_q};
      rsd_pkg::REG_RADIAL_DZ: prdata = {17'd0, rdz_q};
      default:                prdata = '0;
    endcase
  end

  // terms derived from the radial dead zone
  always_ff @(posedge clk_i) begin
    rdz_sq_q <= {15'd0, rdz_q} * {15'd0, rdz_q};
    den_q    <= RTW'((rsd_pkg::FULL_SCALE - 32'(rdz_q)) << 8);
    rdz_ok_q <= (32'(rdz_q) < rsd_pkg::FULL_SCALE);
  end

  // stage 1: axis magnitudes and the per-axis gate
  logic        v1_q, sgnx1_q, sgny1_q, push1_q;
  logic [15:0] ax1_q, ay1_q, ax_d, ay_d;

  assign ax_d = stick_x_i[15] ? 16'(-stick_x_i) : stick_x_i;
  assign ay_d = stick_y_i[15] ? 16'(-stick_y_i) : stick_y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    ax1_q   <= ax_d;
    ay1_q   <= ay_d;
    sgnx1_q <= stick_x_i[15];
    sgny1_q <= stick_y_i[15];
    push1_q <= (ax_d > {1'b0, adz_q}) || (ay_d > {1'b0, adz_q});
  end

  // stage 2: squares
  logic        v2_q;
  logic [31:0] sqx2_q, sqy2_q;
  rsd_pkg::ctx_t ctx2_q, ctx2_d;

  always_comb begin
    ctx2_d        = '0;
    ctx2_d.sign_x = sgnx1_q;
    ctx2_d.sign_y = sgny1_q;
    ctx2_d.ax     = ax1_q;
    ctx2_d.ay     = ay1_q;
    ctx2_d.pushed = push1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sqx2_q <= ax1_q * ax1_q;
    sqy2_q <= ay1_q * ay1_q;
    ctx2_q <= ctx2_d;
  end

  // stage 3: squared length and the radial test
  logic        v3_q;
  logic [31:0] m2_d, m2_3_q;
  rsd_pkg::ctx_t ctx3_q, ctx3_d;

  assign m2_d = sqx2_q + sqy2_q;

  always_comb begin
    ctx3_d      = ctx2_q;
    ctx3_d.live = ctx2_q.pushed && (m2_d > {2'b00, rdz_sq_q}) && rdz_ok_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m2_3_q <= m2_d;
    ctx3_q <= ctx3_d;
  end

  // length in q.8
  logic          sq_v;
  logic [RTW-1:0] sq_root;
  rsd_pkg::ctx_t sq_ctx;

  rsd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .rad_i   ({m2_3_q, 16'd0}),
    .ctx_i   (ctx3_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .ctx_o   (sq_ctx)
  );

  // stage 4: clamp and remove the dead zone
  logic           v4_q;
  logic [RTW-1:0] cmag, num4_q;
  rsd_pkg::ctx_t  ctx4_q, ctx4_d;

  assign cmag = (sq_root > rsd_pkg::FULL_Q8) ? rsd_pkg::FULL_Q8 : sq_root;

  always_comb begin
    ctx4_d      = sq_ctx;
    ctx4_d.magq = sq_root;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    num4_q <= cmag - {1'b0, rdz_q, 8'd0};
    ctx4_q <= ctx4_d;
  end

  // stage 5: saturation check of the tilt quotient
  logic           v5_q;
  logic [RTW-1:0] num5_q;
  rsd_pkg::ctx_t  ctx5_q, ctx5_d;

  always_comb begin
    ctx5_d     = ctx4_q;
    ctx5_d.sat = (num4_q >= den_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num5_q <= num4_q;
    ctx5_q <= ctx5_d;
  end

  // tilt = num * 2^15 / den
  logic          td_v;
  logic [QW-1:0] td_q;
  rsd_pkg::ctx_t td_ctx;

  rsd_div u_div_tilt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .rem_i   (num5_q),
    .low_i   ('0),
    .div_i   (den_q),
    .ctx_i   (ctx5_q),
    .valid_o (td_v),
    .quo_o   (td_q),
    .ctx_o   (td_ctx)
  );

  // stage 6: saturate the tilt
  logic          v6_q;
  rsd_pkg::ctx_t ctx6_q, ctx6_d;

  always_comb begin
    ctx6_d      = td_ctx;
    ctx6_d.tilt = td_ctx.sat ? rsd_pkg::TILT_MAX : td_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= td_v;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx6_q <= ctx6_d;
  end

  // stage 7: axis times tilt
  logic          v7_q;
  logic [30:0]   px7_q, py7_q;
  rsd_pkg::ctx_t ctx7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px7_q  <= ctx6_q.ax * ctx6_q.tilt;
    py7_q  <= ctx6_q.ay * ctx6_q.tilt;
    ctx7_q <= ctx6_q;
  end

  // axis * tilt * 256 / length, one lane per axis
  logic          dx_v, dy_v;
  logic [QW-1:0] qx, qy;
  rsd_pkg::ctx_t dx_ctx, dy_ctx;

  rsd_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v7_q),
    .rem_i   (px7_q[30:7]),
    .low_i   ({px7_q[6:0], 8'd0}),
    .div_i   (ctx7_q.magq),
    .ctx_i   (ctx7_q),
    .valid_o (dx_v),
    .quo_o   (qx),
    .ctx_o   (dx_ctx)
  );

  rsd_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v7_q),
    .rem_i   (py7_q[30:7]),
    .low_i   ({py7_q[6:0], 8'd0}),
    .div_i   (ctx7_q.magq),
    .ctx_i   (ctx7_q),
    .valid_o (dy_v),
    .quo_o   (qy),
    .ctx_o   (dy_ctx)
  );

  // stage 8: signs, zero forcing and the result registers
  logic [15:0] mx, my;

  assign mx = {1'b0, qx};
  assign my = {1'b0, qy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= dx_v && dy_v;
    end
  end

  always_ff @(posedge clk_i) begin
    scaled_x_o    <= !dx_ctx.live ? '0 : (dx_ctx.sign_x ? 16'(-mx) : mx);
    scaled_y_o    <= !dy_ctx.live ? '0 : (dy_ctx.sign_y ? 16'(-my) : my);
    tilt_length_o <= dx_ctx.live ? dx_ctx.tilt : '0;
    pushed_o      <= dx_ctx.pushed;
  end

  // checks
  logic [15:0] abs_x, abs_y;

  assign abs_x = scaled_x_o[15] ? 16'(-scaled_x_o) : scaled_x_o;
  assign abs_y = scaled_y_o[15] ? 16'(-scaled_y_o) : scaled_y_o;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(rsd_pkg::LATENCY) done_o)
    else $error("accepted item gave no result strobe");

  a_not_pushed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !pushed_o) |-> (tilt_length_o == '0))
    else $error("tilt without push");

  a_axis_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((abs_x <= {1'b0, tilt_length_o}) && (abs_y <= {1'b0, tilt_length_o})))
    else $error("scaled axis exceeds tilt length");

endmodule
